/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int CURSOR_W    = 11;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;
    localparam int TAB_BITS    = 3;
    localparam int TAB_STOP    = 8;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_SCROLL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec_put;
        logic exec_read;
        logic scroll_start;
        logic sweep_step;
        logic sweep_blank;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic need_scroll;
        logic sweep_last;
    } sts_t;

endpackage

`default_nettype wire

/* design/text_console_writer_top.sv */
// put: a beat taken in IDLE passes EXEC and CHECK to EMIT, which loads the result register
// read: a beat passes EXEC to EMIT; no new beat is taken until the result is loaded
// a put that scrolls adds one pass over the screen memory, one cell written per cycle
// through its single write port, the cell a row below read through its single read port
// after reset a clearing pass over every cell fills the screen with spaces,
// s_tready stays low until it ends; cursor resets to 0
// ----------------------------------------------------------------------------
// text_console_writer_top
// text console with a character-cell screen, linear cursor and scrolling
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,  // char_code, read_index
    input  wire logic                              s_tuser,  // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tcw_pkg::M_TDATA_W-1:0]     m_tdata   // cursor, scrolled, cell_char
);
    import tcw_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic [CURSOR_W-1:0] cursor;
    logic                scrolled;
    logic [CHAR_W-1:0]   cell_char;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (s_tuser),
        .in_char_code  (s_tdata[CHAR_W-1:0]),
        .in_read_index (s_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
        .out_cursor    (cursor),
        .out_scrolled  (scrolled),
        .out_cell_char (cell_char)
    );

    assign m_tdata = {(M_TDATA_W - CURSOR_W - 1 - CHAR_W)'(0), cell_char, scrolled, cursor};

endmodule

`default_nettype wire

/* design/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer of the text console writer: clear pass, put, read, scroll, output
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  tcw_pkg::sts_t      sts,
    output tcw_pkg::cmd_t      cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_step  = 1'b1;
                cmd.sweep_blank = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.kind == KIND_READ)
                begin
                    cmd.exec_read = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.exec_put = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.need_scroll)
                begin
                    cmd.scroll_start = 1'b1;
                    state_next       = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // result goes out once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* design/tcw_dp.sv */
// ----------------------------------------------------------------------------
// tcw_dp
// datapath of the text console writer: screen memory, cursor, sweep, result
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  tcw_pkg::cmd_t                        cmd,
    output tcw_pkg::sts_t                        sts,
    input  wire logic                            in_kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]     in_read_index,
    output logic      [tcw_pkg::CURSOR_W-1:0]    out_cursor,
    output logic                                 out_scrolled,
    output logic      [tcw_pkg::CHAR_W-1:0]      out_cell_char
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + TAB_STOP);
    localparam int COLW  = $clog2(COLUMNS);

    localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
    localparam logic [CW-1:0]   COLS_CW    = CW'(COLUMNS);
    localparam logic [COLW:0]   COLS_C     = (COLW + 1)'(COLUMNS);
    localparam logic [COLW-1:0] LAST_COL   = COLW'(COLUMNS - 1);
    localparam logic [AW-1:0]   LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0]   KEEP_CELLS = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]   COLS_AW    = AW'(COLUMNS);

    logic [CHAR_W-1:0] mem [CELLS];

    logic                kind_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [CW-1:0]       cursor_reg;
    logic [CW-1:0]       cursor_next;
    logic [COLW-1:0]     col_reg;
    logic [COLW-1:0]     col_next;
    logic                scrolled_reg;
    logic [AW-1:0]       cnt_reg;
    logic                wr_pend_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic                wr_blank_reg;
    logic [CHAR_W-1:0]   rdata_reg;
    logic [CURSOR_W-1:0] out_cursor_reg;
    logic                out_scrolled_reg;
    logic [CHAR_W-1:0]   out_cell_reg;

    logic                is_print;
    logic [COLW:0]       step;
    logic [COLW:0]       col_sum;
    logic [COLW-1:0]     col_adv;
    logic                put_we;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [CHAR_W-1:0]   wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    logic                idx_ok;

    // printable range 0x20 to 0x7f
    assign is_print = !char_reg[7] && (char_reg[6:5] != 2'b00);

    // column advance by one cell or to the next tab stop, wrapping once
    always_comb
    begin
        if (char_reg == CHAR_TAB)
        begin
            step = (COLW + 1)'(4'(TAB_STOP) - {1'b0, cursor_reg[TAB_BITS-1:0]});
        end
        else
        begin
            step = (COLW + 1)'(1);
        end
        col_sum = {1'b0, col_reg} + step;
        if (col_sum >= COLS_C)
        begin
            col_adv = COLW'(col_sum - COLS_C);
        end
        else
        begin
            col_adv = COLW'(col_sum);
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        put_we      = 1'b0;
        priority if (char_reg == CHAR_BS)
        begin
            if (cursor_reg != '0)
            begin
                cursor_next = cursor_reg - CW'(1);
                col_next    = (col_reg == '0) ? LAST_COL : col_reg - COLW'(1);
            end
        end
        else if (char_reg == CHAR_TAB)
        begin
            cursor_next = cursor_reg + CW'(step);
            col_next    = col_adv;
        end
        else if (char_reg == CHAR_CR)
        begin
            cursor_next = cursor_reg - CW'(col_reg);
            col_next    = '0;
        end
        else if (char_reg == CHAR_LF)
        begin
            cursor_next = cursor_reg + COLS_CW - CW'(col_reg);
            col_next    = '0;
        end
        else if (is_print)
        begin
            put_we      = (cursor_reg < CELLS_C);
            cursor_next = cursor_reg + CW'(1);
            col_next    = col_adv;
        end
        else
        begin
            // other bytes leave the cursor where it is
            cursor_next = cursor_reg;
            col_next    = col_reg;
        end
    end

    // write port: pending sweep write, else the put
    always_comb
    begin
        if (wr_pend_reg)
        begin
            we    = 1'b1;
            waddr = wr_addr_reg;
            wdata = wr_blank_reg ? CHAR_SPACE : rdata_reg;
        end
        else
        begin
            we    = cmd.exec_put && put_we;
            waddr = AW'(cursor_reg);
            wdata = char_reg;
        end
    end

    // read port: item read, else the row below during a scroll
    always_comb
    begin
        if (cmd.exec_read)
        begin
            re    = 1'b1;
            raddr = AW'(index_reg);
        end
        else
        begin
            re    = cmd.sweep_step && !cmd.sweep_blank && (cnt_reg < KEEP_CELLS);
            raddr = cnt_reg + COLS_AW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= in_kind;
            char_reg  <= in_char_code;
            index_reg <= in_read_index;
        end
        wr_addr_reg  <= cnt_reg;
        wr_blank_reg <= cmd.sweep_blank || (cnt_reg >= KEEP_CELLS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            col_reg      <= '0;
            scrolled_reg <= 1'b0;
            cnt_reg      <= '0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.sweep_step;
            if (cmd.load_item)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (cmd.scroll_start)
            begin
                scrolled_reg <= 1'b1;
            end
            if (cmd.exec_put)
            begin
                cursor_reg <= cursor_next;
                col_reg    <= col_next;
            end
            else if (cmd.scroll_start)
            begin
                cursor_reg <= cursor_reg - COLS_CW;
            end
            if (cmd.scroll_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
        end
    end

    assign idx_ok = (int'(index_reg) < CELLS);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_cursor_reg   <= CURSOR_W'(cursor_reg);
            out_scrolled_reg <= scrolled_reg;
            out_cell_reg     <= (kind_reg == KIND_READ && idx_ok) ? rdata_reg : '0;
        end
    end

    assign sts.kind        = kind_reg;
    assign sts.need_scroll = (cursor_reg >= CELLS_C);
    assign sts.sweep_last  = (cnt_reg == LAST_CELL);

    assign out_cursor    = out_cursor_reg;
    assign out_scrolled  = out_scrolled_reg;
    assign out_cell_char = out_cell_reg;

endmodule

`default_nettype wire

/* design/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [tcw_pkg::M_TDATA_W-1:0]     m_tdata
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam bit WIDE  = (CELLS > 2048);

    logic [10:0] cur;
    assign cur = m_tdata[10:0];

    // one item in flight: no beat taken right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (WIDE || (int'(cur) < CELLS)))
        else $error("cursor beyond screen");

    // a scroll leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[11]) |-> (WIDE || (int'(cur) >= CELLS - COLUMNS)))
        else $error("cursor not on last row after scroll");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

/* bench/text_console_writer_checker.sv */
// ----------------------------------------------------------------------------
// text_console_writer_checker
// watches both stream channels of the console, keeps a shadow screen and
// cursor, predicts one result per accepted beat and compares it field by field
// ----------------------------------------------------------------------------
module text_console_writer_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   errors,
    output int                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [CHAR_W-1:0] CHAR_DEL = 8'h7F;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic                scrolled;
        logic [CHAR_W-1:0]   cell_char;
    } console_result_t;

    logic [CHAR_W-1:0] shadow_screen [CELLS];
    int                shadow_cursor;
    console_result_t   pending_results [$];
    int                error_count = 0;

    assign errors = error_count;

    function automatic console_result_t apply_console_item(
        logic               kind,
        logic [CHAR_W-1:0]  code,
        logic [INDEX_W-1:0] index
    );
        console_result_t res;
        int              cur;
        res = '0;
        cur = shadow_cursor;
        if (kind == KIND_PUT)
        begin
            if (code == CHAR_BS)
            begin
                if (cur > 0)
                    cur--;
            end
            else if (code == CHAR_TAB)
                cur = (cur + TAB_STOP) & ~(TAB_STOP - 1);
            else if (code == CHAR_CR)
                cur = cur - cur % COLUMNS;
            else if (code == CHAR_LF)
                cur = cur + COLUMNS - cur % COLUMNS;
            else if (code >= CHAR_SPACE && code <= CHAR_DEL)
            begin
                if (cur < CELLS)
                    shadow_screen[cur] = code;
                cur++;
            end
            // cursor ran off the screen: move every row up and blank the last
            if (cur >= CELLS)
            begin
                for (int i = 0; i < CELLS - COLUMNS; i++)
                    shadow_screen[i] = shadow_screen[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    shadow_screen[i] = CHAR_SPACE;
                cur = cur - COLUMNS;
                res.scrolled = 1'b1;
            end
        end
        else if (index < CELLS)
            res.cell_char = shadow_screen[index];
        shadow_cursor = cur;
        res.cursor = cur[CURSOR_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            shadow_cursor = 0;
            foreach (shadow_screen[i])
                shadow_screen[i] = CHAR_SPACE;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_console_item(s_tuser,
                    s_tdata[CHAR_W-1:0], s_tdata[CHAR_W +: INDEX_W]));
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no item waiting: tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("cursor", want.cursor, m_tdata[CURSOR_W-1:0]);
                    check_field("scrolled", want.scrolled, m_tdata[CURSOR_W]);
                    check_field("cell_char", want.cell_char,
                        m_tdata[CURSOR_W+1 +: CHAR_W]);
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

/* bench/text_console_writer_top_tb.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// drives put and read beats into the console with random gaps and output
// stalls, and reports the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int RANDOM_ITEMS = 1530;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int INDEX_MAX    = (1 << INDEX_W) - 1;
    localparam int CHAR_MAX     = (1 << CHAR_W) - 1;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int   errors;
    int   outstanding;
    int   cycle_count   = 0;
    int   ready_hold    = 0;
    logic steady_sender = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    text_console_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // mostly short pauses, now and then a long one
    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: ready runs of random length broken by stalls
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (m_tready)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                m_tready   <= 1'b0;
                ready_hold <= stall_length() - 1;
            end
            else
                ready_hold <= $urandom_range(0, 30);
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
        end
    end

    task automatic send_console_item(
        logic               kind,
        logic [CHAR_W-1:0]  code,
        logic [INDEX_W-1:0] index
    );
        int gap;
        gap = (steady_sender || $urandom_range(0, 1) == 0) ? 0 : stall_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - CHAR_W - INDEX_W){1'b0}}, index, code};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic put_char(logic [CHAR_W-1:0] code);
        send_console_item(KIND_PUT, code, $urandom_range(0, INDEX_MAX));
    endtask

    task automatic read_cell(logic [INDEX_W-1:0] index);
        send_console_item(KIND_READ, $urandom_range(0, CHAR_MAX), index);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blank screen after reset, both ends and past the end
        read_cell(0);
        read_cell(COLUMNS * ROWS - 1);
        read_cell(COLUMNS * ROWS);
        read_cell(INDEX_MAX);
        // backspace at the first cell stays put
        put_char(CHAR_BS);
        // ignored bytes, low controls and negative chars
        put_char(8'h00);
        put_char(8'h1F);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(CHAR_SPACE);
        put_char(8'h7F);
        put_char(8'h41);
        put_char(CHAR_TAB);
        put_char(CHAR_BS);
        put_char(CHAR_CR);
        put_char(CHAR_LF);
        read_cell(0);
        read_cell(1);
        read_cell(2);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                steady_sender = ($urandom_range(0, 2) == 0);
            // hold off once until the block has answered everything
            if (n == RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                if ($urandom_range(0, 9) < 3)
                    read_cell($urandom_range(0, INDEX_MAX));
                else
                    read_cell($urandom_range(0, ROWS - 1) * COLUMNS
                              + $urandom_range(0, COLUMNS / 2 - 1));
            end
            else if (r < 64)
                put_char($urandom_range(8'h20, 8'h7F));
            else if (r < 71)
                put_char(CHAR_LF);
            else if (r < 76)
                put_char(CHAR_CR);
            else if (r < 82)
                put_char(CHAR_BS);
            else if (r < 88)
                put_char(CHAR_TAB);
            else if (r < 94)
                put_char($urandom_range(8'h80, 8'hFF));
            else
                put_char($urandom_range(8'h00, 8'h1F));
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
